@@ sv/bsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared sizes, status codes, register indexes, sequencer states and the
// control types that pass between the allocator's modules.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int MAX_SLOTS  = 1024;
   localparam int WORD_BITS  = 64;
   localparam int MAP_WORDS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int COUNT_W    = SLOT_W + 1;
   localparam int ADDR_W     = 64;
   localparam int SIZE_W     = 32;
   localparam int PROD_W     = SIZE_W + SLOT_W;
   localparam int DIV_STEPS  = SLOT_W + 1;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 2;

   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_NONE_FREE = 2'd1;
   localparam logic [1:0] STATUS_FREED     = 2'd2;
   localparam logic [1:0] STATUS_RANGE     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT  = 2'd2;

   localparam logic [ADDR_W-1:0]  RESET_BUFFER_BASE = '0;
   localparam logic [SIZE_W-1:0]  RESET_SLOT_SIZE   = 32'd64;
   localparam logic [COUNT_W-1:0] RESET_SLOT_COUNT  = COUNT_W'(MAX_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_ADD,
      ST_FSUB,
      ST_DIV,
      ST_FMARK,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      AOP_NONE,
      AOP_MUL,
      AOP_ADD,
      AOP_LOAD_DIFF,
      AOP_DIV_STEP
   } arith_op_type;

   typedef struct packed {
      logic                  clr;
      logic                  set;
      logic [WORD_IDX_W-1:0] word;
      logic [BIT_IDX_W-1:0]  bit_sel;
   } map_cmd_type;

   typedef struct packed {
      logic                 found;
      logic [BIT_IDX_W-1:0] bit_sel;
   } map_scan_type;

endpackage
`default_nettype wire

@@ sv/bitmap_slot_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Hands out the lowest free fixed-size slot of a buffer and takes slots back
// by address.
//
// Requests arrive on the req_ channel (opcode 0 allocates, opcode 1 frees the
// slot holding req_slot_address); each item gives exactly one rsp_ item.
// Registers are written through csr_we, csr_index and csr_wdata; the user
// must write them only while idle, which the block itself does not enforce.
// One item is worked on at a time; req_stall is high from acceptance until
// the result is placed in the output register. An allocate scans one
// 64-bit map word per cycle, then multiplies and adds. A free subtracts the
// base and runs an 11-step restoring divide, one quotient bit per cycle, or
// ends early when the address is rejected. The next item is accepted in the
// cycle after the result registers.
// While rsp_stall holds, the result waits in the output register and a new
// item may be accepted and worked on up to its own result.
// Reset marks every slot free and loads base 0, slot size 64, slot count 1024.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_opcode,
   input  wire logic [bsa_pkg::ADDR_W-1:0]      req_slot_address,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [bsa_pkg::ADDR_W-1:0]           rsp_granted_address,
   output logic [bsa_pkg::SLOT_W-1:0]           rsp_slot_number,
   input  wire logic                            csr_we,
   input  wire logic [bsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bsa_pkg::ADDR_W-1:0]      csr_wdata
);

   bsa_pkg::state_type             state_ff, state_in;
   logic [bsa_pkg::ADDR_W-1:0]     base_ff;
   logic [bsa_pkg::SIZE_W-1:0]     size_ff;
   logic [bsa_pkg::COUNT_W-1:0]    count_ff;
   logic [bsa_pkg::COUNT_W-1:0]    active_count;
   logic [bsa_pkg::WORD_IDX_W-1:0] word_ff, word_in;
   logic [bsa_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [bsa_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [1:0]                     res_status_ff, res_status_in;
   logic [bsa_pkg::SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [bsa_pkg::ADDR_W-1:0]     rsp_gaddr_ff, rsp_gaddr_in;
   logic [bsa_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                           accept;
   logic                           out_free;
   logic                           last_word;
   logic                           last_step;
   bsa_pkg::map_cmd_type           map_cmd;
   bsa_pkg::map_scan_type          scan;
   bsa_pkg::arith_op_type          aop;
   logic                           ge;
   logic [bsa_pkg::SLOT_W-1:0]     quotient;
   logic [bsa_pkg::ADDR_W-1:0]     gaddr;

   assign active_count = (count_ff > bsa_pkg::COUNT_W'(bsa_pkg::MAX_SLOTS))
                         ? bsa_pkg::COUNT_W'(bsa_pkg::MAX_SLOTS) : count_ff;
   assign req_stall = (state_ff != bsa_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_word = (word_ff == bsa_pkg::WORD_IDX_W'(bsa_pkg::MAP_WORDS - 1));
   assign last_step = (step_ff == bsa_pkg::STEP_W'(bsa_pkg::DIV_STEPS - 1));

   bsa_map u_map (
      .clock     (clock),
      .reset     (reset),
      .scan_word (word_ff),
      .count     (active_count),
      .cmd       (map_cmd),
      .scan      (scan)
   );

   bsa_arith u_arith (
      .clock    (clock),
      .aop      (aop),
      .base     (base_ff),
      .size     (size_ff),
      .addr     (addr_ff),
      .slot     (res_slot_ff),
      .ge       (ge),
      .quotient (quotient),
      .gaddr    (gaddr)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_opcode ? bsa_pkg::ST_FSUB : bsa_pkg::ST_SCAN;
            end
         end
         bsa_pkg::ST_SCAN: begin
            if (scan.found) begin
               state_in = bsa_pkg::ST_MUL;
            end else if (last_word) begin
               state_in = bsa_pkg::ST_RESP;
            end
         end
         bsa_pkg::ST_MUL: begin
            state_in = bsa_pkg::ST_ADD;
         end
         bsa_pkg::ST_ADD: begin
            state_in = bsa_pkg::ST_RESP;
         end
         bsa_pkg::ST_FSUB: begin
            if (!ge || size_ff == '0) begin
               state_in = bsa_pkg::ST_RESP;
            end else begin
               state_in = bsa_pkg::ST_DIV;
            end
         end
         bsa_pkg::ST_DIV: begin
            if (step_ff == '0 && ge) begin
               state_in = bsa_pkg::ST_RESP;
            end else if (last_step) begin
               state_in = bsa_pkg::ST_FMARK;
            end
         end
         bsa_pkg::ST_FMARK: begin
            state_in = bsa_pkg::ST_RESP;
         end
         bsa_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = bsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      word_in       = word_ff;
      step_in       = step_ff;
      addr_in       = addr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_gaddr_in  = rsp_gaddr_ff;
      rsp_slot_in   = rsp_slot_ff;
      map_cmd       = '0;
      aop           = bsa_pkg::AOP_NONE;
      case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in = req_slot_address;
               word_in = '0;
            end
         end
         bsa_pkg::ST_SCAN: begin
            if (scan.found) begin
               map_cmd.clr   = 1'b1;
               map_cmd.word  = word_ff;
               map_cmd.bit_sel = scan.bit_sel;
               res_status_in = bsa_pkg::STATUS_ALLOCATED;
               res_slot_in   = bsa_pkg::SLOT_W'({word_ff, scan.bit_sel});
            end else if (last_word) begin
               res_status_in = bsa_pkg::STATUS_NONE_FREE;
               res_slot_in   = '0;
            end else begin
               word_in = word_ff + bsa_pkg::WORD_IDX_W'(1);
            end
         end
         bsa_pkg::ST_MUL: begin
            aop = bsa_pkg::AOP_MUL;
         end
         bsa_pkg::ST_ADD: begin
            aop = bsa_pkg::AOP_ADD;
         end
         bsa_pkg::ST_FSUB: begin
            aop     = bsa_pkg::AOP_LOAD_DIFF;
            step_in = '0;
            if (!ge || size_ff == '0) begin
               res_status_in = bsa_pkg::STATUS_RANGE;
               res_slot_in   = '0;
            end
         end
         bsa_pkg::ST_DIV: begin
            aop     = bsa_pkg::AOP_DIV_STEP;
            step_in = step_ff + bsa_pkg::STEP_W'(1);
            if (step_ff == '0 && ge) begin
               res_status_in = bsa_pkg::STATUS_RANGE;
               res_slot_in   = '0;
            end
         end
         bsa_pkg::ST_FMARK: begin
            if ({1'b0, quotient} >= active_count) begin
               res_status_in = bsa_pkg::STATUS_RANGE;
               res_slot_in   = '0;
            end else begin
               map_cmd.set     = 1'b1;
               map_cmd.word    = quotient[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IDX_W];
               map_cmd.bit_sel = quotient[bsa_pkg::BIT_IDX_W-1:0];
               res_status_in   = bsa_pkg::STATUS_FREED;
               res_slot_in     = quotient;
            end
         end
         bsa_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_gaddr_in  = (res_status_ff == bsa_pkg::STATUS_ALLOCATED) ? gaddr : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= bsa_pkg::RESET_BUFFER_BASE;
         size_ff      <= bsa_pkg::RESET_SLOT_SIZE;
         count_ff     <= bsa_pkg::RESET_SLOT_COUNT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               bsa_pkg::CSR_BUFFER_BASE: base_ff  <= csr_wdata;
               bsa_pkg::CSR_SLOT_SIZE:   size_ff  <= csr_wdata[bsa_pkg::SIZE_W-1:0];
               bsa_pkg::CSR_SLOT_COUNT:  count_ff <= csr_wdata[bsa_pkg::COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      step_ff       <= step_in;
      addr_ff       <= addr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gaddr_ff  <= rsp_gaddr_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_gaddr_ff;
   assign rsp_slot_number     = rsp_slot_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != bsa_pkg::ST_IDLE)
      else $error("Accepted item did not start the sequencer.");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsa_pkg::ST_RESP) && out_free |=>
         rsp_valid && (state_ff == bsa_pkg::ST_IDLE))
      else $error("Result was not loaded into the output register.");

   a_gaddr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bsa_pkg::STATUS_ALLOCATED) |->
         rsp_granted_address == '0)
      else $error("Granted address is nonzero on a non-allocate result.");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bsa_pkg::STATUS_NONE_FREE ||
                    rsp_status == bsa_pkg::STATUS_RANGE) |->
         rsp_slot_number == '0)
      else $error("Slot number is nonzero on a failed request.");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsa_pkg::ST_DIV) |->
         step_ff <= bsa_pkg::STEP_W'(bsa_pkg::DIV_STEPS - 1))
      else $error("Divide step counter ran past its last step.");

endmodule
`default_nettype wire

@@ sv/bsa_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free map storage and word scan
// Holds one bit per slot, set while the slot is free. Masks the scanned word
// to the active slot count and finds its lowest free bit.
// ----------------------------------------------------------------------------
module bsa_map (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [bsa_pkg::WORD_IDX_W-1:0] scan_word,
   input  wire logic [bsa_pkg::COUNT_W-1:0]    count,
   input  wire bsa_pkg::map_cmd_type           cmd,
   output bsa_pkg::map_scan_type               scan
);

   logic [bsa_pkg::WORD_BITS-1:0] map_ff [bsa_pkg::MAP_WORDS];
   logic [bsa_pkg::WORD_BITS-1:0] mask;
   logic [bsa_pkg::WORD_BITS-1:0] avail;
   logic [bsa_pkg::WORD_BITS-1:0] lowest;
   logic [bsa_pkg::COUNT_W-1:0]   first;
   logic [bsa_pkg::COUNT_W-1:0]   left;
   logic [bsa_pkg::BIT_IDX_W-1:0] idx;

   always_comb begin
      first = bsa_pkg::COUNT_W'({scan_word, bsa_pkg::BIT_IDX_W'(0)});
      left  = count - first;
      if (count <= first) begin
         mask = '0;
      end else if (left >= bsa_pkg::COUNT_W'(bsa_pkg::WORD_BITS)) begin
         mask = '1;
      end else begin
         mask = (bsa_pkg::WORD_BITS'(1) << left[bsa_pkg::BIT_IDX_W-1:0])
                - bsa_pkg::WORD_BITS'(1);
      end
      avail  = map_ff[scan_word] & mask;
      lowest = avail & (~avail + bsa_pkg::WORD_BITS'(1));
      idx    = '0;
      for (int i = 0; i < bsa_pkg::WORD_BITS; i++) begin
         if (lowest[i]) begin
            idx = idx | bsa_pkg::BIT_IDX_W'(i);
         end
      end
      scan.found   = |avail;
      scan.bit_sel = idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < bsa_pkg::MAP_WORDS; w++) begin
            map_ff[w] <= '1;
         end
      end else if (cmd.clr) begin
         map_ff[cmd.word] <= map_ff[cmd.word]
                             & ~(bsa_pkg::WORD_BITS'(1) << cmd.bit_sel);
      end else if (cmd.set) begin
         map_ff[cmd.word] <= map_ff[cmd.word]
                             | (bsa_pkg::WORD_BITS'(1) << cmd.bit_sel);
      end
   end

endmodule
`default_nettype wire

@@ sv/bsa_arith.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One 64-bit add/subtract serves the grant address sum, the address offset
// and each restoring divide step; a small multiplier forms slot times size.
// ----------------------------------------------------------------------------
module bsa_arith (
   input  wire logic                        clock,
   input  wire bsa_pkg::arith_op_type       aop,
   input  wire logic [bsa_pkg::ADDR_W-1:0]  base,
   input  wire logic [bsa_pkg::SIZE_W-1:0]  size,
   input  wire logic [bsa_pkg::ADDR_W-1:0]  addr,
   input  wire logic [bsa_pkg::SLOT_W-1:0]  slot,
   output logic                             ge,
   output logic [bsa_pkg::SLOT_W-1:0]       quotient,
   output logic [bsa_pkg::ADDR_W-1:0]       gaddr
);

   logic [bsa_pkg::ADDR_W-1:0] rem_ff, rem_in;
   logic [bsa_pkg::PROD_W-1:0] dvs_ff, dvs_in;
   logic [bsa_pkg::SLOT_W-1:0] q_ff, q_in;
   logic [bsa_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [bsa_pkg::ADDR_W-1:0] gaddr_ff, gaddr_in;
   logic [bsa_pkg::ADDR_W-1:0] op_a;
   logic [bsa_pkg::ADDR_W-1:0] op_b;
   logic                       sub;
   logic [bsa_pkg::ADDR_W:0]   sum;

   always_comb begin
      op_a = '0;
      op_b = '0;
      sub  = 1'b0;
      case (aop)
         bsa_pkg::AOP_ADD: begin
            op_a = base;
            op_b = bsa_pkg::ADDR_W'(prod_ff);
         end
         bsa_pkg::AOP_LOAD_DIFF: begin
            op_a = addr;
            op_b = base;
            sub  = 1'b1;
         end
         bsa_pkg::AOP_DIV_STEP: begin
            op_a = rem_ff;
            op_b = bsa_pkg::ADDR_W'(dvs_ff);
            sub  = 1'b1;
         end
         default: begin
         end
      endcase
      sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)}
            + (bsa_pkg::ADDR_W + 1)'(sub);
      ge  = sum[bsa_pkg::ADDR_W];
   end

   always_comb begin
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      q_in     = q_ff;
      prod_in  = prod_ff;
      gaddr_in = gaddr_ff;
      case (aop)
         bsa_pkg::AOP_MUL: begin
            prod_in = bsa_pkg::PROD_W'(slot) * bsa_pkg::PROD_W'(size);
         end
         bsa_pkg::AOP_ADD: begin
            gaddr_in = sum[bsa_pkg::ADDR_W-1:0];
         end
         bsa_pkg::AOP_LOAD_DIFF: begin
            rem_in = sum[bsa_pkg::ADDR_W-1:0];
            dvs_in = {size, bsa_pkg::SLOT_W'(0)};
            q_in   = '0;
         end
         bsa_pkg::AOP_DIV_STEP: begin
            if (ge) begin
               rem_in = sum[bsa_pkg::ADDR_W-1:0];
            end
            q_in   = {q_ff[bsa_pkg::SLOT_W-2:0], ge};
            dvs_in = dvs_ff >> 1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      q_ff     <= q_in;
      prod_ff  <= prod_in;
      gaddr_ff <= gaddr_in;
   end

   assign quotient = q_ff;
   assign gaddr    = gaddr_ff;

endmodule
`default_nettype wire
